[design/csd_pkg.sv]
// Shared types, constants and decode functions for the cube display block.
package csd_pkg;

  localparam logic [4:0]  MaxBaseLimit  = 5'd21;
  localparam logic [4:0]  ResetMaxBase  = 5'd21;
  localparam logic [15:0] ResetScans    = 16'd250;

  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  // register index, taken from the word address bit
  localparam logic RegMaxBase = 1'b0;
  localparam logic RegScans   = 1'b1;

  typedef logic [3:0][3:0] digits_t;

  // gfedcba pattern of one decimal digit, blank for other codes
  function automatic logic [6:0] seg_code(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // slot 0 is the ones digit on the rightmost position
  function automatic logic [3:0] select_code(input logic [1:0] slot);
    logic [3:0] c;
    unique case (slot)
      2'd0:    c = 4'h8;
      2'd1:    c = 4'h4;
      2'd2:    c = 4'h2;
      default: c = 4'h1;
    endcase
    return c;
  endfunction

  // weight of the digit position being extracted
  function automatic logic [9:0] place_weight(input logic [1:0] pos);
    logic [9:0] w;
    unique case (pos)
      2'd3:    w = 10'd1000;
      2'd2:    w = 10'd100;
      default: w = 10'd10;
    endcase
    return w;
  endfunction

endpackage

[design/csd_if.sv]
// Valid/ready channels for scan ticks and display words.
interface csd_in_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface csd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] segments;
  logic [3:0] digit_select;
  logic [4:0] base_shown;
  logic [13:0] number_shown;
  modport source (output valid, output segments, output digit_select,
                  output base_shown, output number_shown, input ready);
  modport sink (input valid, input segments, input digit_select,
                input base_shown, input number_shown, output ready);
endinterface

[design/csd_regs.sv]
// APB register file: max_base and scans_per_value.
module csd_regs import csd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output logic [4:0]           max_base_o,
  output logic [15:0]          scans_per_value_o
);

  logic [4:0]  max_base_q;
  logic [15:0] scans_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_base_q <= ResetMaxBase;
      scans_q    <= ResetScans;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegMaxBase: max_base_q <= pwdata[4:0];
        RegScans:   scans_q    <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegMaxBase: prdata = {{(DataWidth-5){1'b0}}, max_base_q};
      RegScans:   prdata = {{(DataWidth-16){1'b0}}, scans_q};
      default:    prdata = '0;
    endcase
  end

  assign max_base_o        = max_base_q;
  assign scans_per_value_o = scans_q;

endmodule

[design/csd_conv.sv]
// Base register with iterative cube and decimal digit extraction.
module csd_conv import csd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [4:0]  base_i,
  output logic        busy_o,
  output logic [4:0]  base_o,
  output logic [13:0] cube_o,
  output digits_t     digits_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSq   = 2'd1;
  localparam logic [1:0] StCube = 2'd2;
  localparam logic [1:0] StDig  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [4:0]  base_q, base_d;
  logic [9:0]  sq_q, sq_d;
  logic [13:0] cube_q, cube_d;
  logic [13:0] rem_q, rem_d;
  logic [1:0]  pos_q, pos_d;
  logic [3:0]  cnt_q, cnt_d;
  digits_t     dig_q, dig_d;

  logic [9:0]  mul_a;
  logic [14:0] prod;
  logic [13:0] weight;
  logic        fits;

  // one multiplier: base * base first, then square * base
  assign mul_a  = (state_q == StSq) ? {5'd0, base_q} : sq_q;
  assign prod   = {5'd0, mul_a} * {10'd0, base_q};
  assign weight = {4'd0, place_weight(pos_q)};
  assign fits   = rem_q >= weight;

  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    sq_d    = sq_q;
    cube_d  = cube_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    dig_d   = dig_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          base_d  = base_i;
          state_d = StSq;
        end
      end
      StSq: begin
        sq_d    = prod[9:0];
        state_d = StCube;
      end
      StCube: begin
        cube_d  = prod[13:0];
        rem_d   = prod[13:0];
        pos_d   = 2'd3;
        cnt_d   = 4'd0;
        state_d = StDig;
      end
      StDig: begin
        // one compare-subtract per cycle; a miss closes the digit
        if (fits) begin
          rem_d = rem_q - weight;
          cnt_d = cnt_q + 4'd1;
        end else begin
          dig_d[pos_q] = cnt_q;
          cnt_d        = 4'd0;
          if (pos_q == 2'd1) begin
            dig_d[0] = rem_q[3:0];
            state_d  = StIdle;
          end else begin
            pos_d = pos_q - 2'd1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      base_q  <= 5'd1;
      cube_q  <= 14'd1;
      dig_q   <= {4'd0, 4'd0, 4'd0, 4'd1};
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      cube_q  <= cube_d;
      dig_q   <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q  <= sq_d;
    rem_q <= rem_d;
    pos_q <= pos_d;
    cnt_q <= cnt_d;
  end

  assign busy_o   = state_q != StIdle;
  assign base_o   = base_q;
  assign cube_o   = cube_q;
  assign digits_o = dig_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == StIdle) |=> busy_o)
    else $error("conversion did not start");

  a_digits_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |->
      ({4'd0, dig_q[3]} * 14'd1000 + {4'd0, dig_q[2]} * 14'd100 +
       {4'd0, dig_q[1]} * 14'd10 + {10'd0, dig_q[0]}) == cube_q)
    else $error("held digits disagree with cube");

  a_base_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (base_q >= 5'd1 && base_q <= MaxBaseLimit))
    else $error("base out of range");

  a_digit_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDig) |-> cnt_q <= 4'd9)
    else $error("digit count overran");

endmodule

[design/cube_sequence_seven_segment_display.sv]
// Each accepted word yields one registered display word, and a word with tick
// set moves the scan on one slot. The word holds the segments and one-hot
// select of the current digit (ones, tens, hundreds, thousands), the base and
// its cube. After scans_per_value full scans (zero acts as one) the base steps
// (wrapping to 1 after max_base, where zero acts as one and the cap is 21) and
// the block goes busy while a shared multiplier squares and cubes the base and
// a single compare-subtract unit peels off thousands, hundreds and tens, one
// step per cycle; no tick is taken while it is busy.
module cube_sequence_seven_segment_display import csd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  csd_in_if.sink               in_if,
  csd_out_if.source            out_if,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  logic [4:0]  max_base;
  logic [15:0] scans_per_value;
  logic        busy;
  logic [4:0]  base;
  logic [13:0] cube;
  digits_t     digits;

  logic [1:0]  slot_q;
  logic [15:0] repeat_q;
  logic        out_valid_q;
  logic [6:0]  seg_q;
  logic [3:0]  sel_q;
  logic [4:0]  base_out_q;
  logic [13:0] num_out_q;

  logic        accept;
  logic        step;
  logic        scan_done;
  logic [16:0] rep_inc;
  logic [16:0] need;
  logic        advance;
  logic [4:0]  top;
  logic [4:0]  next_base;

  csd_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .max_base_o        (max_base),
    .scans_per_value_o (scans_per_value)
  );

  assign in_if.ready = !busy && (!out_valid_q || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;
  assign step        = accept && in_if.tick;
  assign scan_done   = step && (slot_q == 2'd3);
  assign rep_inc     = {1'b0, repeat_q} + 17'd1;
  assign need        = (scans_per_value == 16'd0) ? 17'd1 : {1'b0, scans_per_value};
  assign advance     = scan_done && (rep_inc >= need);

  always_comb begin
    priority if (max_base == 5'd0) begin
      top = 5'd1;
    end else if (max_base > MaxBaseLimit) begin
      top = MaxBaseLimit;
    end else begin
      top = max_base;
    end
  end

  assign next_base = (base >= top) ? 5'd1 : base + 5'd1;

  csd_conv u_conv (
    .clk_i,
    .rst_ni,
    .start_i  (advance),
    .base_i   (next_base),
    .busy_o   (busy),
    .base_o   (base),
    .cube_o   (cube),
    .digits_o (digits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= 2'd0;
      repeat_q    <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        slot_q <= slot_q + 2'd1;
      end
      if (advance) begin
        repeat_q <= 16'd0;
      end else if (scan_done) begin
        repeat_q <= rep_inc[15:0];
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // word shows the slot as it stood before this tick
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seg_q      <= seg_code(digits[slot_q]);
      sel_q      <= select_code(slot_q);
      base_out_q <= base;
      num_out_q  <= cube;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.segments     = seg_q;
  assign out_if.digit_select = sel_q;
  assign out_if.base_shown   = base_out_q;
  assign out_if.number_shown = num_out_q;

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_if.ready)
    else $error("tick taken during conversion");

  a_adv_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> slot_q == 2'd0 && repeat_q == 16'd0)
    else $error("advance without scan wrap");

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot(sel_q))
    else $error("digit select not one-hot");

endmodule

[sim/tb_cube_sequence_seven_segment_display.sv]
// Self-checking testbench for the cube display: directed table, then random phases.
`timescale 1ns / 1ps

module tb_cube_sequence_seven_segment_display import csd_pkg::*; ();

  localparam int unsigned TimeoutNs = 2000000;
  localparam int unsigned QuietCycles = 40;
  localparam int unsigned LongHold = 300;
  localparam int unsigned HoldAfter = 200;
  localparam logic [9:0][6:0] SegOf = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                       7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  typedef struct packed {
    logic [6:0]  seg;
    logic [3:0]  sel;
    logic [4:0]  base;
    logic [13:0] num;
  } disp_word_t;

  typedef enum int {RowTick, RowSetMax, RowSetScans} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    int unsigned value;
    bit          typed;
    disp_word_t  want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  csd_in_if  tick_ch ();
  csd_out_if disp_ch ();

  cube_sequence_seven_segment_display i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (tick_ch),
    .out_if  (disp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // display state as the block should hold it
  logic [4:0]  cfg_max;
  logic [15:0] cfg_scans;
  logic [4:0]  cur_base;
  logic [13:0] cur_cube;
  logic [3:0]  cur_digits [4];
  logic [1:0]  cur_slot;
  logic [16:0] scan_reps;

  disp_word_t expect_q [$];
  dir_row_t   dir_rows [$];
  int         mismatches;
  int         results_seen;
  int         src_pct;
  int         snk_pct;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic void seat_base(input int unsigned b);
    int unsigned v;
    cur_base = b[4:0];
    v = cur_base;
    v = v * v * v;
    cur_cube = 14'(v);
    v = cur_cube;
    for (int i = 0; i < 4; i++) begin
      cur_digits[i] = 4'(v % 10);
      v = v / 10;
    end
  endfunction

  // word shown for the current slot; a tick then moves the scan on
  function automatic disp_word_t show_slot(input logic t);
    disp_word_t  w;
    logic [4:0]  top;
    int unsigned need;
    w.seg  = (cur_digits[cur_slot] < 10) ? SegOf[cur_digits[cur_slot]] : 7'h00;
    w.sel  = 4'h8 >> cur_slot;
    w.base = cur_base;
    w.num  = cur_cube;
    if (t) begin
      cur_slot = cur_slot + 2'd1;
      if (cur_slot == 2'd0) begin
        scan_reps = scan_reps + 17'd1;
        need = (cfg_scans == 16'd0) ? 1 : cfg_scans;
        if (scan_reps >= need) begin
          scan_reps = '0;
          top = (cfg_max == 5'd0) ? 5'd1 : (cfg_max > MaxBaseLimit) ? MaxBaseLimit : cfg_max;
          seat_base((cur_base >= top) ? 1 : cur_base + 1);
        end
      end
    end
    return w;
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  // enters at a posedge or negedge, returns at the posedge that took the word
  task automatic send_tick(input logic t, input bit typed, input disp_word_t want);
    int         gap;
    disp_word_t w;
    gap = pick_gap(src_pct);
    @(negedge clk_i);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.tick  <= t;
    do @(posedge clk_i); while (!tick_ch.ready);
    w = show_slot(t);
    expect_q.push_back(typed ? want : w);
  endtask

  // register writes only once the block has gone quiet
  task automatic set_reg(input logic idx, input int unsigned val);
    logic [31:0] mask;
    mask = (idx == RegScans) ? 32'h0000_FFFF : 32'h0000_001F;
    @(negedge clk_i);
    tick_ch.valid <= 1'b0;
    while (expect_q.size() != 0) @(negedge clk_i);
    repeat (QuietCycles) @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~mask) | (val & mask);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegMaxBase) cfg_max = val[4:0];
    else cfg_scans = val[15:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned max_v, input int unsigned scans_v,
                           input int n);
    set_reg(RegMaxBase, max_v);
    set_reg(RegScans, scans_v);
    src_pct = pick_pct();
    snk_pct = pick_pct();
    repeat (n) send_tick($urandom_range(0, 99) < 85, 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk_i) begin : check_words
    disp_word_t got;
    disp_word_t want;
    if (rst_ni && disp_ch.valid && disp_ch.ready) begin
      got = '{disp_ch.segments, disp_ch.digit_select, disp_ch.base_shown,
              disp_ch.number_shown};
      results_seen++;
      if (expect_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected word seg=%h sel=%h base=%0d num=%0d",
                   $realtime, got.seg, got.sel, got.base, got.num);
        mismatches++;
      end else begin
        want = expect_q.pop_front();
        if (got.seg !== want.seg || got.sel !== want.sel ||
            got.base !== want.base || got.num !== want.num) begin
          if (mismatches < 10)
            $display("%0t: word mismatch exp seg=%h sel=%h base=%0d num=%0d, got seg=%h sel=%h base=%0d num=%0d",
                     $realtime, want.seg, want.sel, want.base, want.num,
                     got.seg, got.sel, got.base, got.num);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the input
  initial begin : drive_ready
    int  stall_left;
    bit  held;
    stall_left = 0;
    held = 1'b0;
    disp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= HoldAfter) begin
        held = 1'b1;
        stall_left = LongHold;
      end
      if (stall_left == 0) stall_left = pick_gap(snk_pct);
      if (stall_left > 0) begin
        stall_left--;
        disp_ch.ready <= 1'b0;
      end else begin
        disp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tick_ch.valid = 1'b0;
    tick_ch.tick  = 1'b0;
    mismatches    = 0;
    results_seen  = 0;
    src_pct       = 20;
    snk_pct       = 20;
    cfg_max       = ResetMaxBase;
    cfg_scans     = ResetScans;
    cur_slot      = '0;
    scan_reps     = '0;
    seat_base(1);

    // reset view: ones digit of 1, then zeros on the upper digits
    dir_rows.push_back('{RowTick, 0, 1'b1, '{7'h06, 4'h8, 5'd1, 14'd1}});
    dir_rows.push_back('{RowTick, 1, 1'b1, '{7'h06, 4'h8, 5'd1, 14'd1}});
    dir_rows.push_back('{RowTick, 1, 1'b1, '{7'h3F, 4'h4, 5'd1, 14'd1}});
    dir_rows.push_back('{RowTick, 1, 1'b1, '{7'h3F, 4'h2, 5'd1, 14'd1}});
    dir_rows.push_back('{RowTick, 1, 1'b1, '{7'h3F, 4'h1, 5'd1, 14'd1}});
    dir_rows.push_back('{RowTick, 0, 1'b1, '{7'h06, 4'h8, 5'd1, 14'd1}});
    // zero scans acts as one, and the repeat count has already reached it
    dir_rows.push_back('{RowSetScans, 0, 1'b0, '0});
    repeat (4) dir_rows.push_back('{RowTick, 1, 1'b0, '0});
    dir_rows.push_back('{RowTick, 0, 1'b1, '{7'h7F, 4'h8, 5'd2, 14'd8}});
    // zero max base acts as one: base 2 wraps back to 1
    dir_rows.push_back('{RowSetMax, 0, 1'b0, '0});
    repeat (4) dir_rows.push_back('{RowTick, 1, 1'b0, '0});
    dir_rows.push_back('{RowTick, 0, 1'b1, '{7'h06, 4'h8, 5'd1, 14'd1}});
    // max base above the limit saturates
    dir_rows.push_back('{RowSetMax, 31, 1'b0, '0});
    repeat (4) dir_rows.push_back('{RowTick, 1, 1'b0, '0});
    dir_rows.push_back('{RowTick, 0, 1'b1, '{7'h7F, 4'h8, 5'd2, 14'd8}});

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        RowTick:     send_tick(dir_rows[i].value[0], dir_rows[i].typed, dir_rows[i].want);
        RowSetMax:   set_reg(RegMaxBase, dir_rows[i].value);
        RowSetScans: set_reg(RegScans, dir_rows[i].value);
        default:     ;
      endcase
    end

    run_phase(21, 1, 350);
    run_phase(31, 2, 200);
    run_phase(5, 3, 150);
    run_phase(0, 1, 80);
    run_phase(1, 0, 80);
    run_phase(21, 65535, 60);
    run_phase(21, 250, 60);
    // scans lowered below the repeat count already reached
    run_phase(21, 3, 60);
    repeat (6) run_phase($urandom_range(0, 31), $urandom_range(0, 6), 60);

    @(negedge clk_i);
    tick_ch.valid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
    if (mismatches == 0 && expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/csd_pkg.sv
design/csd_if.sv
design/csd_regs.sv
design/csd_conv.sv
design/cube_sequence_seven_segment_display.sv
sim/tb_cube_sequence_seven_segment_display.sv
